/* hdl/pms_pkg.sv */
// Shared types and constants of the partitioned multi-stack unit.
`default_nettype none

package pms_pkg;

  // Request codes carried on the request channel.
  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_STATUS = 2'd3
  } req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_e;

  localparam int StackIdxW = 3;
  localparam int ActiveW   = 4;
  localparam int CapW      = 7;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 7;

  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_STACKS  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STACK_CAPACITY = 2'd1;

  localparam logic [ActiveW-1:0] ActiveReset = 4'd8;
  localparam logic [CapW-1:0]    CapReset    = 7'd64;

endpackage

`default_nettype wire

/* hdl/pms_if.sv */
// Request and result channel interfaces of the partitioned multi-stack unit.
`default_nettype none

interface pms_req_if #(
  parameter int DataWidth = 32
);
  logic                                   valid;
  logic                                   ready;
  pms_pkg::req_e                          req_type;
  logic        [pms_pkg::StackIdxW-1:0]   stack_index;
  logic signed [DataWidth-1:0]            push_value;

  modport source (output valid, output req_type, output stack_index, output push_value,
                  input ready);
  modport sink   (input valid, input req_type, input stack_index, input push_value,
                  output ready);
endinterface

interface pms_rsp_if #(
  parameter int DataWidth = 32
);
  logic                        valid;
  logic                        ready;
  pms_pkg::status_e            status;
  logic signed [DataWidth-1:0] data_out;
  logic                        stack_full;
  logic                        stack_empty;

  modport source (output valid, output status, output data_out, output stack_full,
                  output stack_empty, input ready);
  modport sink   (input valid, input status, input data_out, input stack_full,
                  input stack_empty, output ready);
endinterface

`default_nettype wire

/* hdl/partitioned_multi_stack_unit.sv */
// Top level of the partitioned multi-stack unit: several stacks sharing one entry memory.
//
//   channel   direction  handshake        payload
//   req_i     in         valid / ready    req_type, stack_index, push_value
//   rsp_o     out        valid / ready    status, data_out, stack_full, stack_empty
//   cfg_*_i   in         we only          index 0 active stacks, index 1 stack capacity
//
// One item is worked on at a time: accept (fill count read), count update with the
// entry memory access, an extra state for the read data of a pop or peek that returns
// an entry, then hand-off to the output register. The output register lets the next
// item be accepted while a result waits; a stalled output holds the unit in its
// hand-off state. Reset empties every stack at once.
`default_nettype none

module partitioned_multi_stack_unit #(
  parameter int MAX_STACKS = 8,
  parameter int MAX_DEPTH  = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  pms_req_if.sink                             req_i,
  pms_rsp_if.source                           rsp_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [pms_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [pms_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int StoreDepth = MAX_STACKS * MAX_DEPTH;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int CntW       = $clog2(MAX_DEPTH + 1);
  localparam int StkW       = $clog2(MAX_STACKS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_COUNT = 4'b0010,
    S_READ  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [pms_pkg::ActiveW-1:0] active_q;
  logic [pms_pkg::CapW-1:0]    cap_q;

  pms_pkg::req_e                   req_q;
  logic [pms_pkg::StackIdxW-1:0]   sidx_q;
  logic signed [DATA_WIDTH-1:0]    val_q;
  logic [AddrW-1:0]                base_q;

  pms_pkg::status_e             res_status_q, res_status_d;
  logic signed [DATA_WIDTH-1:0] res_data_q, res_data_d;
  logic                         res_full_q, res_full_d;
  logic                         res_empty_q, res_empty_d;

  logic                         out_valid_q, out_valid_d;
  pms_pkg::status_e             out_status_q;
  logic signed [DATA_WIDTH-1:0] out_data_q;
  logic                         out_full_q;
  logic                         out_empty_q;
  logic                         out_load;

  // Fill counts live in a small memory; a per-stack valid bit stands for the reset value.
  logic [CntW-1:0]       cnt_mem [MAX_STACKS];
  logic [MAX_STACKS-1:0] cnt_vld_q;
  logic [CntW-1:0]       cnt_rd_q;
  logic                  cnt_we;
  logic [StkW-1:0]       cnt_raddr;
  logic [StkW-1:0]       cnt_waddr;
  logic [CntW-1:0]       cnt_cur;
  logic [CntW-1:0]       cnt_new;

  logic [DATA_WIDTH-1:0] store_mem [StoreDepth];
  logic [DATA_WIDTH-1:0] store_rd_q;
  logic                  store_we;
  logic [AddrW-1:0]      store_addr;

  logic            accept;
  logic [CntW-1:0] eff_cap;
  logic            invalid;
  logic            is_push;
  logic            is_read;
  logic            overflow;
  logic            underflow;
  logic            read_ok;

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // A capacity above the store's partition size saturates.
  assign eff_cap = (int'(cap_q) > MAX_DEPTH) ? CntW'(MAX_DEPTH) : CntW'(cap_q);

  assign cnt_raddr = StkW'(req_i.stack_index);
  assign cnt_waddr = StkW'(sidx_q);
  assign cnt_cur   = cnt_vld_q[cnt_waddr] ? cnt_rd_q : '0;

  assign invalid   = ({1'b0, sidx_q} >= active_q) || (int'(sidx_q) >= MAX_STACKS);
  assign is_push   = (req_q == pms_pkg::REQ_PUSH);
  assign is_read   = (req_q == pms_pkg::REQ_POP) || (req_q == pms_pkg::REQ_PEEK);
  assign overflow  = is_push && (cnt_cur >= eff_cap);
  assign underflow = is_read && (cnt_cur == '0);
  assign read_ok   = !invalid && is_read && !underflow;

  always_comb begin
    cnt_new = cnt_cur;
    if (is_push && !overflow) begin
      cnt_new = cnt_cur + CntW'(1);
    end else if ((req_q == pms_pkg::REQ_POP) && !underflow) begin
      cnt_new = cnt_cur - CntW'(1);
    end
  end

  // A push writes at the current count, a pop or peek reads the entry below it.
  assign store_addr = is_push ? (base_q + AddrW'(cnt_cur))
                              : (base_q + AddrW'(cnt_cur - CntW'(1)));
  assign store_we   = (state_q == S_COUNT) && !invalid && is_push && !overflow;
  assign cnt_we     = (state_q == S_COUNT) && !invalid;

  // The count of an item is written back before the next item can read it, so the
  // count read taken at acceptance never overlaps a write of the same entry.
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_new;
    end
    cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[store_addr] <= DATA_WIDTH'(val_q);
    end
    store_rd_q <= store_mem[store_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (cnt_we) begin
      cnt_vld_q[cnt_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= pms_pkg::ActiveReset;
      cap_q    <= pms_pkg::CapReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pms_pkg::CFG_ACTIVE_STACKS:  active_q <= cfg_data_i[pms_pkg::ActiveW-1:0];
        pms_pkg::CFG_STACK_CAPACITY: cap_q    <= cfg_data_i[pms_pkg::CapW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_full_d   = res_full_q;
    res_empty_d  = res_empty_q;
    out_load     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_COUNT;
        end
      end
      S_COUNT: begin
        res_data_d = '1;
        if (invalid) begin
          res_status_d = pms_pkg::ST_INVALID;
          res_full_d   = 1'b0;
          res_empty_d  = 1'b0;
        end else begin
          if (overflow) begin
            res_status_d = pms_pkg::ST_OVERFLOW;
          end else if (underflow) begin
            res_status_d = pms_pkg::ST_UNDERFLOW;
          end else begin
            res_status_d = pms_pkg::ST_OK;
          end
          res_full_d  = (cnt_new >= eff_cap);
          res_empty_d = (cnt_new == '0);
        end
        state_d = read_ok ? S_READ : S_EMIT;
      end
      S_READ: begin
        res_data_d = store_rd_q;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_i.req_type;
      sidx_q <= req_i.stack_index;
      val_q  <= DATA_WIDTH'(req_i.push_value);
      base_q <= AddrW'(32'(req_i.stack_index) * 32'(eff_cap));
    end
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_full_q   <= res_full_d;
    res_empty_q  <= res_empty_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
      out_full_q   <= res_full_q;
      out_empty_q  <= res_empty_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.data_out    = out_data_q;
  assign rsp_o.stack_full  = out_full_q;
  assign rsp_o.stack_empty = out_empty_q;

endmodule

`default_nettype wire

/* tb/tb_partitioned_multi_stack_unit.sv */
// Self-checking testbench for the partitioned multi-stack unit, with directed and random phases.

module tb_partitioned_multi_stack_unit;

  localparam int NumStacks   = 8;
  localparam int MaxDepth    = 64;
  localparam int DataW       = 32;
  localparam int StoreDepth  = NumStacks * MaxDepth;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 400000;
  localparam int PrintLimit  = 100;
  localparam int NumPhases   = 12;

  typedef struct {
    pms_pkg::status_e status;
    logic [DataW-1:0] data;
    logic             full;
    logic             empty;
  } stack_rsp_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [pms_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [pms_pkg::CfgDataW-1:0] cfg_data_i;

  pms_req_if #(.DataWidth(DataW)) req_bus ();
  pms_rsp_if #(.DataWidth(DataW)) rsp_bus ();

  partitioned_multi_stack_unit #(
    .MAX_STACKS(NumStacks),
    .MAX_DEPTH (MaxDepth),
    .DATA_WIDTH(DataW)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_bus),
    .rsp_o     (rsp_bus),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Mirror of the stacks, kept in step with every accepted item.
  logic [pms_pkg::CapW-1:0]    fill_cnt      [NumStacks];
  logic [DataW-1:0]            entry_mem     [StoreDepth];
  bit                          entry_written [StoreDepth];
  logic [pms_pkg::ActiveW-1:0] active_stacks_reg;
  logic [pms_pkg::CapW-1:0]    capacity_reg;

  stack_rsp_t pending_results [$];
  int         send_idle_pct;
  int         recv_stall_pct;
  int         mismatch_count;
  int         results_seen;
  int         cycle_count;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL partitioned_multi_stack_unit");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int active_limit();
    return (active_stacks_reg > NumStacks) ? NumStacks : int'(active_stacks_reg);
  endfunction

  function automatic int capacity_limit();
    return (capacity_reg > MaxDepth) ? MaxDepth : int'(capacity_reg);
  endfunction

  function automatic int entry_addr(input int s, input int k);
    int a;
    a = s * capacity_limit() + k;
    return (a < StoreDepth) ? a : 0;
  endfunction

  // A pop or peek may only touch an entry that has been pushed since reset.
  function automatic bit top_readable(input int s);
    if (s >= active_limit() || fill_cnt[s] == 0) return 1'b1;
    return entry_written[entry_addr(s, int'(fill_cnt[s]) - 1)];
  endfunction

  function automatic stack_rsp_t apply_stack_op(input pms_pkg::req_e op, input int s,
                                                input logic [DataW-1:0] val);
    stack_rsp_t r;
    int cnt;
    int cap;
    cap = capacity_limit();
    r.status = pms_pkg::ST_OK;
    r.data   = '1;
    r.full   = 1'b0;
    r.empty  = 1'b0;
    if (s >= active_limit()) begin
      r.status = pms_pkg::ST_INVALID;
    end else begin
      cnt = fill_cnt[s];
      case (op)
        pms_pkg::REQ_PUSH: begin
          if (cnt >= cap) begin
            r.status = pms_pkg::ST_OVERFLOW;
          end else begin
            entry_mem[entry_addr(s, cnt)]     = val;
            entry_written[entry_addr(s, cnt)] = 1'b1;
            cnt++;
          end
        end
        pms_pkg::REQ_POP, pms_pkg::REQ_PEEK: begin
          if (cnt == 0) begin
            r.status = pms_pkg::ST_UNDERFLOW;
          end else begin
            r.data = entry_mem[entry_addr(s, cnt - 1)];
            if (op == pms_pkg::REQ_POP) cnt--;
          end
        end
        default: ;
      endcase
      fill_cnt[s] = cnt[pms_pkg::CapW-1:0];
      r.full      = (cnt >= cap);
      r.empty     = (cnt == 0);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [DataW-1:0] want,
                                 input logic [DataW-1:0] got);
    mismatch_count++;
    if (mismatch_count <= PrintLimit)
      $display("mismatch at result %0d: %s expected %h got %h", results_seen, field, want, got);
  endtask

  always @(posedge clk_i) begin : check_results
    stack_rsp_t want;
    if (rst_ni === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request", '0, rsp_bus.data_out);
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.status !== want.status)
          report_mismatch("status", DataW'(want.status), DataW'(rsp_bus.status));
        if (rsp_bus.data_out !== want.data)
          report_mismatch("data_out", want.data, rsp_bus.data_out);
        if (rsp_bus.stack_full !== want.full)
          report_mismatch("stack_full", DataW'(want.full), DataW'(rsp_bus.stack_full));
        if (rsp_bus.stack_empty !== want.empty)
          report_mismatch("stack_empty", DataW'(want.empty), DataW'(rsp_bus.stack_empty));
      end
      results_seen++;
    end
  end

  // The valid line stays high after acceptance so that a following item can go
  // out at once; it is lowered only by an idle cycle or by settle.
  task automatic send_req(input pms_pkg::req_e op, input int idx,
                          input logic [DataW-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= op;
    req_bus.stack_index <= idx[pms_pkg::StackIdxW-1:0];
    req_bus.push_value  <= val;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    pending_results.push_back(apply_stack_op(op, idx, val));
  endtask

  task automatic settle();
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [pms_pkg::CfgIdxW-1:0] idx, input int value);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[pms_pkg::CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pms_pkg::CFG_ACTIVE_STACKS:  active_stacks_reg = value[pms_pkg::ActiveW-1:0];
      pms_pkg::CFG_STACK_CAPACITY: capacity_reg      = value[pms_pkg::CapW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_random_op(input int push_pct);
    pms_pkg::req_e    op;
    int               s;
    int               r;
    logic [DataW-1:0] val;
    if (active_limit() > 0 && $urandom_range(9) != 0) s = $urandom_range(active_limit() - 1);
    else s = $urandom_range(NumStacks - 1);
    r = $urandom_range(99);
    if (r < push_pct) begin
      op = pms_pkg::REQ_PUSH;
    end else begin
      r  = $urandom_range(99);
      op = (r < 60) ? pms_pkg::REQ_POP : (r < 85) ? pms_pkg::REQ_PEEK : pms_pkg::REQ_STATUS;
    end
    if ((op == pms_pkg::REQ_POP || op == pms_pkg::REQ_PEEK) && !top_readable(s))
      op = pms_pkg::REQ_PUSH;
    val = $urandom;
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0:       val = '0;
        1:       val = '1;
        2:       val = 32'h7FFF_FFFF;
        default: val = 32'h8000_0000;
      endcase
    end
    send_req(op, s, val);
  endtask

  task automatic test_reset_state();
    send_req(pms_pkg::REQ_STATUS, 0, $urandom);
    send_req(pms_pkg::REQ_PEEK, 2, $urandom);
    send_req(pms_pkg::REQ_POP, 5, $urandom);
  endtask

  task automatic test_push_pop_extremes();
    send_req(pms_pkg::REQ_PUSH, 7, 32'h7FFF_FFFF);
    send_req(pms_pkg::REQ_PUSH, 7, 32'h8000_0000);
    send_req(pms_pkg::REQ_PUSH, 7, 32'hFFFF_FFFF);
    send_req(pms_pkg::REQ_PUSH, 7, 32'h0000_0000);
    send_req(pms_pkg::REQ_PEEK, 7, $urandom);
    repeat (4) send_req(pms_pkg::REQ_POP, 7, $urandom);
  endtask

  task automatic test_full_and_overflow();
    write_reg(pms_pkg::CFG_STACK_CAPACITY, 1);
    send_req(pms_pkg::REQ_PUSH, 4, 32'h5A5A_A5A5);
    send_req(pms_pkg::REQ_PUSH, 4, 32'h1234_5678);
    send_req(pms_pkg::REQ_POP, 4, $urandom);
    // With no room at all, every stack is both full and empty.
    write_reg(pms_pkg::CFG_STACK_CAPACITY, 0);
    send_req(pms_pkg::REQ_PUSH, 2, $urandom);
    send_req(pms_pkg::REQ_PEEK, 2, $urandom);
  endtask

  task automatic test_invalid_index();
    write_reg(pms_pkg::CFG_ACTIVE_STACKS, 0);
    send_req(pms_pkg::REQ_STATUS, 0, $urandom);
    send_req(pms_pkg::REQ_PUSH, 3, $urandom);
    // Out-of-range settings saturate to the hardware limits.
    write_reg(pms_pkg::CFG_ACTIVE_STACKS, 15);
    write_reg(pms_pkg::CFG_STACK_CAPACITY, 127);
    send_req(pms_pkg::REQ_PUSH, 7, 32'hCAFE_F00D);
    send_req(pms_pkg::REQ_POP, 7, $urandom);
    write_reg(pms_pkg::CFG_ACTIVE_STACKS, 3);
    send_req(pms_pkg::REQ_POP, 5, $urandom);
  endtask

  // Stack 0 starts at address zero for any capacity, so its entries stay
  // reachable when the capacity drops below its fill count.
  task automatic test_count_over_capacity();
    write_reg(pms_pkg::CFG_ACTIVE_STACKS, 8);
    write_reg(pms_pkg::CFG_STACK_CAPACITY, 4);
    send_req(pms_pkg::REQ_PUSH, 0, 32'h0000_0011);
    send_req(pms_pkg::REQ_PUSH, 0, 32'h0000_0022);
    send_req(pms_pkg::REQ_PUSH, 0, 32'h0000_0033);
    write_reg(pms_pkg::CFG_STACK_CAPACITY, 2);
    send_req(pms_pkg::REQ_STATUS, 0, $urandom);
    send_req(pms_pkg::REQ_POP, 0, $urandom);
    send_req(pms_pkg::REQ_PUSH, 0, 32'h0000_0044);
    send_req(pms_pkg::REQ_POP, 0, $urandom);
    send_req(pms_pkg::REQ_POP, 0, $urandom);
  endtask

  // Each phase sets both registers and an idling mode, then alternates
  // filling and draining stretches so that stacks reach full and empty.
  task automatic test_random_traffic();
    int act_tab   [NumPhases] = '{8, 3, 15, 1, 8, 0, 5, 8, 2, 8, 4, 1};
    int cap_tab   [NumPhases] = '{4, 2, 6, 64, 1, 5, 127, 64, 0, 3, 100, 8};
    int count_tab [NumPhases] = '{137, 137, 137, 220, 137, 60, 137, 137, 137, 137, 137, 137};
    int stall_tab [4]         = '{0, 0, 64, 38};
    int idle_tab  [4]         = '{0, 64, 0, 38};
    for (int p = 0; p < NumPhases; p++) begin
      write_reg(pms_pkg::CFG_ACTIVE_STACKS, act_tab[p]);
      write_reg(pms_pkg::CFG_STACK_CAPACITY, cap_tab[p]);
      send_idle_pct  = idle_tab[p % 4];
      recv_stall_pct = stall_tab[p % 4];
      for (int n = 0; n < count_tab[p]; n++)
        send_random_op(((n / 40) % 2 == 0) ? 90 : 25);
    end
  endtask

  initial begin
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= '0;
    cfg_data_i          <= '0;
    req_bus.valid       <= 1'b0;
    req_bus.req_type    <= pms_pkg::REQ_STATUS;
    req_bus.stack_index <= '0;
    req_bus.push_value  <= '0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    active_stacks_reg   = pms_pkg::ActiveReset;
    capacity_reg        = pms_pkg::CapReset;
    foreach (fill_cnt[i]) fill_cnt[i] = '0;
    foreach (entry_written[i]) entry_written[i] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_push_pop_extremes();
    test_full_and_overflow();
    test_invalid_index();
    test_count_over_capacity();
    test_random_traffic();

    settle();
    if (mismatch_count == 0) begin
      $display("PASS partitioned_multi_stack_unit");
    end else begin
      $display("FAIL partitioned_multi_stack_unit");
    end
    $finish;
  end

endmodule
